### hdl/aapr_pkg.sv
`default_nettype none
package aapr_pkg;

    localparam int XW  = 32;
    localparam int DW  = 33;
    localparam int CFW = 18;
    localparam int QW  = 20;
    localparam int OPW = 34;
    localparam int PW  = 68;

    localparam logic [CFW-1:0] COS_RESET = 18'd65534;
    localparam logic [CFW-1:0] SIN_RESET = 18'd572;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_COS = 2'd0;
    localparam t_cfg_idx CFG_SIN = 2'd1;

    typedef enum logic [1:0] {
        ST_ROTATED    = 2'd0,
        ST_AXIS_SET   = 2'd1,
        ST_DEGENERATE = 2'd2,
        ST_SATURATED  = 2'd3
    } t_status;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_DIFF,
        OP_SQ_MUL,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_IDENT,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_WR,
        OP_QUAT_MUL,
        OP_QUAT_WR,
        OP_MAT_MUL,
        OP_MAT_WR,
        OP_RDIFF,
        OP_ROT_MUL,
        OP_ROT_WR,
        OP_OUT_WR
    } t_dp_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIFF,
        S_SQ,
        S_SQ_DRAIN,
        S_SQRT_INIT,
        S_SQRT,
        S_CHECK,
        S_DIV_INIT,
        S_DIV,
        S_DIV_WR,
        S_QUAT_MUL,
        S_QUAT_WR,
        S_MAT,
        S_RDIFF,
        S_ROT,
        S_OUT
    } t_state;

    typedef struct packed {
        t_dp_op     op;
        logic [3:0] idx;
        logic [1:0] sub;
        t_status    kind;
    } t_cmd;

    typedef struct packed {
        logic root_zero;
        logic out_free;
    } t_dp_stat;

    typedef struct packed {
        logic [1:0] qa;
        logic [1:0] qb;
        logic       neg;
        logic       diag;
    } t_mat_term;

    // Each matrix entry is an optional one plus two signed terms 2*qa*qb.
    function automatic t_mat_term mat_term(input logic [3:0] e, input logic t);
        t_mat_term m;
        m = '{qa: 2'd0, qb: 2'd0, neg: 1'b0, diag: 1'b0};
        case (e)
            4'd0: m = t ? '{2'd3, 2'd3, 1'b1, 1'b1} : '{2'd2, 2'd2, 1'b1, 1'b1};
            4'd1: m = t ? '{2'd0, 2'd3, 1'b1, 1'b0} : '{2'd1, 2'd2, 1'b0, 1'b0};
            4'd2: m = t ? '{2'd0, 2'd2, 1'b0, 1'b0} : '{2'd1, 2'd3, 1'b0, 1'b0};
            4'd3: m = t ? '{2'd0, 2'd3, 1'b0, 1'b0} : '{2'd1, 2'd2, 1'b0, 1'b0};
            4'd4: m = t ? '{2'd1, 2'd1, 1'b1, 1'b1} : '{2'd3, 2'd3, 1'b1, 1'b1};
            4'd5: m = t ? '{2'd0, 2'd1, 1'b1, 1'b0} : '{2'd2, 2'd3, 1'b0, 1'b0};
            4'd6: m = t ? '{2'd0, 2'd2, 1'b1, 1'b0} : '{2'd1, 2'd3, 1'b0, 1'b0};
            4'd7: m = t ? '{2'd0, 2'd1, 1'b0, 1'b0} : '{2'd2, 2'd3, 1'b0, 1'b0};
            4'd8: m = t ? '{2'd2, 2'd2, 1'b1, 1'b1} : '{2'd1, 2'd1, 1'b1, 1'b1};
            default: m = '{qa: 2'd0, qb: 2'd0, neg: 1'b0, diag: 1'b0};
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

### hdl/aapr_ctrl.sv
`default_nettype none
module aapr_ctrl #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_operation,
    input  wire aapr_pkg::t_dp_stat i_stat,
    output aapr_pkg::t_cmd          o_cmd,
    output logic                    o_in_stall
);
    import aapr_pkg::*;

    localparam int NW = 33 + FRAC_BITS;
    localparam int CW = $clog2(NW);

    t_state        r_state, n_state;
    logic [3:0]    r_idx, n_idx;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_rot, n_rot;
    logic          r_degen, n_degen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_cnt   <= '0;
            r_rot   <= 1'b0;
            r_degen <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_cnt   <= n_cnt;
            r_rot   <= n_rot;
            r_degen <= n_degen;
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_cnt   = r_cnt;
        n_rot   = r_rot;
        n_degen = r_degen;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_rot   = i_operation;
                    n_state = i_operation ? S_RDIFF : S_DIFF;
                end
            end
            S_DIFF: begin
                n_idx   = '0;
                n_state = S_SQ;
            end
            S_SQ: begin
                if (r_idx == 4'd2) begin
                    n_state = S_SQ_DRAIN;
                end else begin
                    n_idx = r_idx + 4'd1;
                end
            end
            S_SQ_DRAIN: n_state = S_SQRT_INIT;
            S_SQRT_INIT: begin
                n_cnt   = '0;
                n_state = S_SQRT;
            end
            S_SQRT: begin
                if (r_cnt == CW'(31)) begin
                    n_state = S_CHECK;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            S_CHECK: begin
                n_degen = i_stat.root_zero;
                n_idx   = '0;
                n_state = i_stat.root_zero ? S_OUT : S_DIV_INIT;
            end
            S_DIV_INIT: begin
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (r_cnt == CW'(NW - 1)) begin
                    n_state = S_DIV_WR;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            S_DIV_WR: begin
                if (r_idx == 4'd2) begin
                    n_idx   = '0;
                    n_state = S_QUAT_MUL;
                end else begin
                    n_idx   = r_idx + 4'd1;
                    n_state = S_DIV_INIT;
                end
            end
            S_QUAT_MUL: n_state = S_QUAT_WR;
            S_QUAT_WR: begin
                n_cnt = '0;
                if (r_idx == 4'd2) begin
                    n_idx   = '0;
                    n_state = S_MAT;
                end else begin
                    n_idx   = r_idx + 4'd1;
                    n_state = S_QUAT_MUL;
                end
            end
            S_MAT: begin
                if (r_cnt == CW'(3)) begin
                    n_cnt = '0;
                    if (r_idx == 4'd8) begin
                        n_state = S_OUT;
                    end else begin
                        n_idx = r_idx + 4'd1;
                    end
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            S_RDIFF: begin
                n_idx   = '0;
                n_cnt   = '0;
                n_state = S_ROT;
            end
            S_ROT: begin
                if (r_cnt == CW'(4)) begin
                    n_cnt = '0;
                    if (r_idx == 4'd2) begin
                        n_state = S_OUT;
                    end else begin
                        n_idx = r_idx + 4'd1;
                    end
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op   = OP_NOP;
        o_cmd.idx  = r_idx;
        o_cmd.sub  = r_cnt[1:0];
        o_cmd.kind = r_rot ? ST_ROTATED : (r_degen ? ST_DEGENERATE : ST_AXIS_SET);
        o_in_stall = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE:      o_cmd.op = i_in_valid ? OP_LOAD : OP_NOP;
            S_DIFF:      o_cmd.op = OP_DIFF;
            S_SQ:        o_cmd.op = OP_SQ_MUL;
            S_SQ_DRAIN:  o_cmd.op = OP_NOP;
            S_SQRT_INIT: o_cmd.op = OP_SQRT_INIT;
            S_SQRT:      o_cmd.op = OP_SQRT_STEP;
            S_CHECK:     o_cmd.op = i_stat.root_zero ? OP_IDENT : OP_NOP;
            S_DIV_INIT:  o_cmd.op = OP_DIV_INIT;
            S_DIV:       o_cmd.op = OP_DIV_STEP;
            S_DIV_WR:    o_cmd.op = OP_DIV_WR;
            S_QUAT_MUL:  o_cmd.op = OP_QUAT_MUL;
            S_QUAT_WR:   o_cmd.op = OP_QUAT_WR;
            S_MAT: begin
                case (r_cnt[1:0])
                    2'd0, 2'd1: o_cmd.op = OP_MAT_MUL;
                    2'd3:       o_cmd.op = OP_MAT_WR;
                    default:    o_cmd.op = OP_NOP;
                endcase
            end
            S_RDIFF:     o_cmd.op = OP_RDIFF;
            S_ROT: begin
                if (r_cnt == CW'(4)) begin
                    o_cmd.op = OP_ROT_WR;
                end else if (r_cnt == CW'(3)) begin
                    o_cmd.op = OP_NOP;
                end else begin
                    o_cmd.op = OP_ROT_MUL;
                end
            end
            S_OUT:       o_cmd.op = i_stat.out_free ? OP_OUT_WR : OP_NOP;
            default:     o_cmd.op = OP_NOP;
        endcase
    end

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == OP_OUT_WR) |-> i_stat.out_free)
        else $error("result written while the output register is held");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state != S_IDLE))
        else $error("accepted request did not start work");

    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt <= CW'(NW - 1)))
        else $error("division step count out of range");

    a_rot_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROT) |-> r_rot)
        else $error("rotation sequence on a set-axis request");

endmodule
`default_nettype wire

### hdl/aapr_datapath.sv
`default_nettype none
module aapr_datapath #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire aapr_pkg::t_cmd        i_cmd,
    output aapr_pkg::t_dp_stat         o_stat,
    input  wire logic                  i_cfg_valid,
    input  wire aapr_pkg::t_cfg_idx    i_cfg_index,
    input  wire logic [17:0]           i_cfg_data,
    input  wire logic signed [31:0]    i_ax,
    input  wire logic signed [31:0]    i_ay,
    input  wire logic signed [31:0]    i_az,
    input  wire logic signed [31:0]    i_bx,
    input  wire logic signed [31:0]    i_by_coord,
    input  wire logic signed [31:0]    i_bz,
    input  wire logic                  i_negative_turn,
    input  wire logic                  i_last_point,
    input  wire logic                  i_out_stall,
    output logic                       o_out_valid,
    output logic signed [31:0]         o_rx,
    output logic signed [31:0]         o_ry,
    output logic signed [31:0]         o_rz,
    output logic [1:0]                 o_status,
    output logic                       o_last_out
);
    import aapr_pkg::*;

    localparam int F  = FRAC_BITS;
    localparam int NW = 33 + F;
    localparam int MW = F + 2;
    localparam int UW = F + 2;

    localparam logic signed [PW-1:0] P_ONE   = {{(PW-1){1'b0}}, 1'b1};
    localparam logic signed [PW-1:0] HALF    = P_ONE <<< (F - 1);
    localparam logic signed [PW-1:0] UNIT2   = P_ONE <<< (2 * F);
    localparam logic signed [PW-1:0] MAT_HI  = {{(PW-F-1){1'b0}}, {(F+1){1'b1}}};
    localparam logic signed [PW-1:0] MAT_LO  = {{(PW-F-1){1'b1}}, {(F+1){1'b0}}};
    localparam logic signed [PW-1:0] C_MAX   = {{(PW-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [PW-1:0] C_MIN   = {{(PW-31){1'b1}}, {31{1'b0}}};
    localparam logic [NW-1:0]        UNIT_Q  = {{(NW-1){1'b0}}, 1'b1} << F;
    localparam logic signed [MW-1:0] MAT_ID  = {{(MW-1){1'b0}}, 1'b1} << F;

    logic signed [CFW-1:0] r_cos, r_sin;
    logic signed [XW-1:0]  r_pivot [3];
    logic signed [MW-1:0]  r_mat [9];
    logic                  r_out_valid;

    logic signed [XW-1:0]  r_a [3];
    logic signed [XW-1:0]  r_b [3];
    logic                  r_neg, r_last, r_pend_last;
    logic [XW-1:0]         r_m [3];
    logic                  r_dneg [3];
    logic signed [DW-1:0]  r_pd [3];
    logic signed [PW-1:0]  r_prod, r_acc;
    logic                  r_pend;
    logic [63:0]           r_sx, r_sr, r_sbit;
    logic [NW-1:0]         r_num, r_quo;
    logic [XW-1:0]         r_rem;
    logic signed [UW-1:0]  r_u [3];
    logic signed [QW-1:0]  r_q1, r_q2, r_q3;
    logic signed [XW-1:0]  r_res [3];
    logic                  r_sat;
    logic signed [XW-1:0]  r_rx, r_ry, r_rz;
    t_status               r_status;

    logic [1:0]            i2;
    logic [3:0]            mat_idx;
    t_mat_term             term;
    logic signed [QW-1:0]  qa_v, qb_v;
    logic signed [18:0]    sin_ext, s_val;
    logic signed [OPW-1:0] op_a, op_b, qa2;
    logic signed [PW-1:0]  prod, acc_rnd, prod_rnd, mat_v, rot_v;
    logic signed [DW-1:0]  dif [3];
    logic [DW-1:0]         mag [3];
    logic                  big;
    logic [63:0]           sq_t;
    logic [XW-1:0]         root;
    logic [XW:0]           rem_sh;
    logic                  q_bit;
    logic [NW-1:0]         quo_sat;
    logic signed [UW-1:0]  u_mag;
    logic signed [XW-1:0]  rot_c;
    logic                  rot_s;

    assign i2      = i_cmd.idx[1:0];
    assign mat_idx = (i_cmd.idx << 1) + i_cmd.idx + {2'b00, i_cmd.sub};
    assign term    = mat_term(i_cmd.idx, i_cmd.sub[0]);
    assign sin_ext = 19'(r_sin);
    assign s_val   = r_neg ? -sin_ext : sin_ext;
    assign root    = r_sr[XW-1:0];

    always_comb begin
        case (term.qa)
            2'd0:    qa_v = QW'(r_cos);
            2'd1:    qa_v = r_q1;
            2'd2:    qa_v = r_q2;
            default: qa_v = r_q3;
        endcase
        case (term.qb)
            2'd0:    qb_v = QW'(r_cos);
            2'd1:    qb_v = r_q1;
            2'd2:    qb_v = r_q2;
            default: qb_v = r_q3;
        endcase
    end

    always_comb begin
        qa2  = OPW'(qa_v) <<< 1;
        op_a = '0;
        op_b = '0;
        case (i_cmd.op)
            OP_SQ_MUL: begin
                op_a = {2'b00, r_m[i2]};
                op_b = {2'b00, r_m[i2]};
            end
            OP_QUAT_MUL: begin
                op_a = OPW'(s_val);
                op_b = OPW'(r_u[i2]);
            end
            OP_MAT_MUL: begin
                op_a = term.neg ? -qa2 : qa2;
                op_b = OPW'(qb_v);
            end
            OP_ROT_MUL: begin
                op_a = OPW'(r_mat[mat_idx]);
                op_b = OPW'(r_pd[i_cmd.sub]);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
        prod = op_a * op_b;
    end

    always_comb begin
        big = 1'b0;
        for (int k = 0; k < 3; k++) begin
            dif[k] = DW'(r_b[k]) - DW'(r_a[k]);
            mag[k] = dif[k][DW-1] ? DW'(-dif[k]) : DW'(dif[k]);
            if (mag[k][DW-1:DW-2] != 2'b00) begin
                big = 1'b1;
            end
        end
    end

    always_comb begin
        acc_rnd  = (r_acc + HALF) >>> F;
        prod_rnd = (r_prod + HALF) >>> F;
        if (acc_rnd > MAT_HI) begin
            mat_v = MAT_HI;
        end else if (acc_rnd < MAT_LO) begin
            mat_v = MAT_LO;
        end else begin
            mat_v = acc_rnd;
        end
        rot_v = acc_rnd + PW'(r_pivot[i2]);
        rot_s = 1'b1;
        if (rot_v > C_MAX) begin
            rot_c = XW'(C_MAX);
        end else if (rot_v < C_MIN) begin
            rot_c = XW'(C_MIN);
        end else begin
            rot_c = XW'(rot_v);
            rot_s = 1'b0;
        end
        sq_t    = r_sr + r_sbit;
        rem_sh  = {r_rem, r_num[NW-1]};
        q_bit   = (rem_sh >= {1'b0, root});
        quo_sat = (r_quo > UNIT_Q) ? UNIT_Q : r_quo;
        u_mag   = UW'(quo_sat);
    end

    assign o_stat.root_zero = (r_sr == '0);
    assign o_stat.out_free  = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos       <= COS_RESET;
            r_sin       <= SIN_RESET;
            r_out_valid <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_pivot[k] <= '0;
            end
            for (int k = 0; k < 9; k++) begin
                r_mat[k] <= (k % 4 == 0) ? MAT_ID : '0;
            end
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_COS: r_cos <= i_cfg_data;
                    CFG_SIN: r_sin <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.op == OP_OUT_WR) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.op == OP_DIFF) begin
                for (int k = 0; k < 3; k++) begin
                    r_pivot[k] <= r_b[k];
                end
            end
            if (i_cmd.op == OP_IDENT) begin
                for (int k = 0; k < 9; k++) begin
                    r_mat[k] <= (k % 4 == 0) ? MAT_ID : '0;
                end
            end
            if (i_cmd.op == OP_MAT_WR) begin
                r_mat[i_cmd.idx] <= MW'(mat_v);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= prod;
        r_pend <= (i_cmd.op == OP_SQ_MUL) || (i_cmd.op == OP_MAT_MUL) ||
                  (i_cmd.op == OP_ROT_MUL);
        if ((i_cmd.op == OP_MAT_MUL) && (i_cmd.sub == 2'd0)) begin
            r_acc <= term.diag ? UNIT2 : '0;
        end else if (((i_cmd.op == OP_ROT_MUL) && (i_cmd.sub == 2'd0)) ||
                     (i_cmd.op == OP_DIFF)) begin
            r_acc <= '0;
        end else if (r_pend) begin
            r_acc <= r_acc + r_prod;
        end
        case (i_cmd.op)
            OP_LOAD: begin
                r_a[0] <= i_ax;
                r_a[1] <= i_ay;
                r_a[2] <= i_az;
                r_b[0] <= i_bx;
                r_b[1] <= i_by_coord;
                r_b[2] <= i_bz;
                r_neg  <= i_negative_turn;
                r_last <= i_last_point;
                r_sat  <= 1'b0;
            end
            OP_DIFF: begin
                for (int k = 0; k < 3; k++) begin
                    r_dneg[k] <= dif[k][DW-1];
                    r_m[k]    <= big ? mag[k][DW-1:1] : mag[k][XW-1:0];
                end
            end
            OP_SQRT_INIT: begin
                r_sx   <= r_acc[63:0];
                r_sr   <= '0;
                r_sbit <= 64'h4000_0000_0000_0000;
            end
            OP_SQRT_STEP: begin
                if (r_sx >= sq_t) begin
                    r_sx <= r_sx - sq_t;
                    r_sr <= (r_sr >> 1) + r_sbit;
                end else begin
                    r_sr <= r_sr >> 1;
                end
                r_sbit <= r_sbit >> 2;
            end
            OP_DIV_INIT: begin
                r_num <= {1'b0, r_m[i2], {F{1'b0}}} + NW'(root[XW-1:1]);
                r_rem <= '0;
                r_quo <= '0;
            end
            OP_DIV_STEP: begin
                r_rem <= q_bit ? XW'(rem_sh - {1'b0, root}) : rem_sh[XW-1:0];
                r_num <= r_num << 1;
                r_quo <= {r_quo[NW-2:0], q_bit};
            end
            OP_DIV_WR: r_u[i2] <= r_dneg[i2] ? -u_mag : u_mag;
            OP_QUAT_WR: begin
                case (i2)
                    2'd0:    r_q1 <= QW'(prod_rnd);
                    2'd1:    r_q2 <= QW'(prod_rnd);
                    default: r_q3 <= QW'(prod_rnd);
                endcase
            end
            OP_RDIFF: begin
                for (int k = 0; k < 3; k++) begin
                    r_pd[k] <= DW'(r_a[k]) - DW'(r_pivot[k]);
                end
            end
            OP_ROT_WR: begin
                r_res[i2] <= rot_c;
                r_sat     <= r_sat | rot_s;
            end
            OP_OUT_WR: begin
                if (i_cmd.kind == ST_ROTATED) begin
                    r_rx     <= r_res[0];
                    r_ry     <= r_res[1];
                    r_rz     <= r_res[2];
                    r_status <= r_sat ? ST_SATURATED : ST_ROTATED;
                end else begin
                    r_rx     <= '0;
                    r_ry     <= '0;
                    r_rz     <= '0;
                    r_status <= i_cmd.kind;
                end
                r_pend_last <= r_last;
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_rx        = r_rx;
    assign o_ry        = r_ry;
    assign o_rz        = r_rz;
    assign o_status    = r_status;
    assign o_last_out  = r_pend_last;

endmodule
`default_nettype wire

### hdl/axis_angle_point_rotator_top.sv
// Channel    Direction  Handshake               Payload
// input      in         i_in_valid / o_in_stall  operation, ax..bz, negative_turn, last_point
// result     out        o_out_valid / i_out_stall rx, ry, rz, status, last_out
// config     in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A rotate request forms its differences to the pivot, then takes three products, a drain
// and a write per row on one multiplier before the result reaches the output register.
// A set-axis request runs a 32-step square root and three bit-serial divisions of
// 33 + FRAC_BITS steps each.
// Reset restores the identity matrix, a zero pivot and the default cosine and sine.
// The input stalls until the result is written; a stalled output holds only that write.
`default_nettype none
module axis_angle_point_rotator_top #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic                 i_operation,
    input  wire logic signed [31:0]   i_ax,
    input  wire logic signed [31:0]   i_ay,
    input  wire logic signed [31:0]   i_az,
    input  wire logic signed [31:0]   i_bx,
    input  wire logic signed [31:0]   i_by_coord,
    input  wire logic signed [31:0]   i_bz,
    input  wire logic                 i_negative_turn,
    input  wire logic                 i_last_point,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic signed [31:0]        o_rx,
    output logic signed [31:0]        o_ry,
    output logic signed [31:0]        o_rz,
    output logic [1:0]                o_status,
    output logic                      o_last_out,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire aapr_pkg::t_cfg_idx   i_cfg_index,
    input  wire logic [17:0]          i_cfg_data
);
    import aapr_pkg::*;

    t_cmd     cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    aapr_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall)
    );

    aapr_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_ax            (i_ax),
        .i_ay            (i_ay),
        .i_az            (i_az),
        .i_bx            (i_bx),
        .i_by_coord      (i_by_coord),
        .i_bz            (i_bz),
        .i_negative_turn (i_negative_turn),
        .i_last_point    (i_last_point),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_rx            (o_rx),
        .o_ry            (o_ry),
        .o_rz            (o_rz),
        .o_status        (o_status),
        .o_last_out      (o_last_out)
    );

endmodule
`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import aapr_pkg::*;

    localparam int FB = 16;

    typedef struct {
        logic        op;
        logic [31:0] ax, ay, az, bx, by, bz;
        logic        neg, last;
    } t_req;

    typedef struct {
        logic [31:0] rx, ry, rz;
        logic [1:0]  st;
        logic        last;
    } t_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic i_operation = 1'b0;
    logic signed [31:0] i_ax = '0, i_ay = '0, i_az = '0;
    logic signed [31:0] i_bx = '0, i_by_coord = '0, i_bz = '0;
    logic i_negative_turn = 1'b0, i_last_point = 1'b0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic signed [31:0] o_rx, o_ry, o_rz;
    logic [1:0] o_status;
    logic o_last_out;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    t_cfg_idx i_cfg_index = CFG_COS;
    logic [17:0] i_cfg_data = '0;

    axis_angle_point_rotator_top #(.FRAC_BITS(FB)) u_top (.*);

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    t_req pending_reqs[$];
    t_res expected_points[$];
    longint cos_h, sin_h;
    longint pivot[3];
    longint rmat[9];
    int errors = 0;
    int send_wait = 0;
    int recv_wait = 0;

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    function automatic longint rnd_q(input longint x);
        return (x + (64'sd1 <<< (FB - 1))) >>> FB;
    endfunction

    function automatic longint clampl(input longint x, input longint lo, input longint hi);
        return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    function automatic longint mat_sat(input longint v);
        longint lim;
        lim = 64'sd1 <<< (FB + 1);
        return clampl(rnd_q(v), -lim, lim - 1);
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic void reset_rotator();
        cos_h = 65534;
        sin_h = 572;
        for (int i = 0; i < 3; i++) pivot[i] = 0;
        for (int i = 0; i < 9; i++) rmat[i] = (i % 4 == 0) ? (64'sd1 <<< FB) : 0;
    endfunction

    function automatic t_res rotate_or_set(input t_req r);
        t_res o;
        longint a[3], b[3], d[3], u[3], q0, q1, q2, q3, s, one, acc, v;
        longint unsigned m[3], sum, n, q;
        logic big, sat;
        a[0] = $signed(r.ax); a[1] = $signed(r.ay); a[2] = $signed(r.az);
        b[0] = $signed(r.bx); b[1] = $signed(r.by); b[2] = $signed(r.bz);
        o.rx = 0; o.ry = 0; o.rz = 0;
        o.last = r.last;
        if (!r.op) begin
            big = 1'b0;
            sum = 0;
            for (int i = 0; i < 3; i++) begin
                pivot[i] = b[i];
                d[i] = b[i] - a[i];
                m[i] = d[i] < 0 ? -d[i] : d[i];
                if (m[i] >= (64'd1 << 31)) big = 1'b1;
            end
            for (int i = 0; i < 3; i++) begin
                if (big) m[i] >>= 1;
                sum += m[i] * m[i];
            end
            n = int_sqrt(sum);
            if (n == 0) begin
                for (int i = 0; i < 9; i++) rmat[i] = (i % 4 == 0) ? (64'sd1 <<< FB) : 0;
                o.st = ST_DEGENERATE;
            end else begin
                for (int i = 0; i < 3; i++) begin
                    q = ((m[i] << FB) + (n >> 1)) / n;
                    if (q > (64'd1 << FB)) q = 64'd1 << FB;
                    u[i] = d[i] < 0 ? -longint'(q) : longint'(q);
                end
                s = r.neg ? -sin_h : sin_h;
                q0 = cos_h;
                q1 = rnd_q(s * u[0]);
                q2 = rnd_q(s * u[1]);
                q3 = rnd_q(s * u[2]);
                one = 64'sd1 <<< (2 * FB);
                rmat[0] = mat_sat(one - 2 * q2 * q2 - 2 * q3 * q3);
                rmat[4] = mat_sat(one - 2 * q3 * q3 - 2 * q1 * q1);
                rmat[8] = mat_sat(one - 2 * q1 * q1 - 2 * q2 * q2);
                rmat[1] = mat_sat(2 * q1 * q2 - 2 * q0 * q3);
                rmat[3] = mat_sat(2 * q1 * q2 + 2 * q0 * q3);
                rmat[2] = mat_sat(2 * q1 * q3 + 2 * q0 * q2);
                rmat[6] = mat_sat(2 * q1 * q3 - 2 * q0 * q2);
                rmat[5] = mat_sat(2 * q2 * q3 - 2 * q0 * q1);
                rmat[7] = mat_sat(2 * q2 * q3 + 2 * q0 * q1);
                o.st = ST_AXIS_SET;
            end
        end else begin
            sat = 1'b0;
            for (int i = 0; i < 3; i++) begin
                acc = 0;
                for (int j = 0; j < 3; j++) acc += rmat[i * 3 + j] * (a[j] - pivot[j]);
                v = rnd_q(acc) + pivot[i];
                d[i] = clampl(v, -64'sd2147483648, 64'sd2147483647);
                if (d[i] != v) sat = 1'b1;
            end
            o.rx = d[0][31:0]; o.ry = d[1][31:0]; o.rz = d[2][31:0];
            o.st = sat ? ST_SATURATED : ST_ROTATED;
        end
        return o;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                expected_points.push_back(rotate_or_set(pending_reqs.pop_front()));
                send_wait = $urandom_range(0, 6);
                if ($urandom_range(0, 3) == 0) send_wait = 0;
            end
            if (!(i_in_valid && o_in_stall)) begin
                if (send_wait > 0) begin
                    send_wait--;
                    i_in_valid <= 1'b0;
                end else if (pending_reqs.size() > 0 && !i_cfg_valid) begin
                    i_in_valid <= 1'b1;
                    i_operation <= pending_reqs[0].op;
                    i_ax <= pending_reqs[0].ax;
                    i_ay <= pending_reqs[0].ay;
                    i_az <= pending_reqs[0].az;
                    i_bx <= pending_reqs[0].bx;
                    i_by_coord <= pending_reqs[0].by;
                    i_bz <= pending_reqs[0].bz;
                    i_negative_turn <= pending_reqs[0].neg;
                    i_last_point <= pending_reqs[0].last;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_points.size() == 0) begin
                    report("unexpected result");
                end else begin
                    e = expected_points.pop_front();
                    if (o_rx !== e.rx) report($sformatf("rx %h exp %h", o_rx, e.rx));
                    if (o_ry !== e.ry) report($sformatf("ry %h exp %h", o_ry, e.ry));
                    if (o_rz !== e.rz) report($sformatf("rz %h exp %h", o_rz, e.rz));
                    if (o_status !== e.st) report($sformatf("status %0d exp %0d", o_status, e.st));
                    if (o_last_out !== e.last) report("last_out");
                end
                recv_wait = $urandom_range(0, 6);
                if ($urandom_range(0, 3) == 0) recv_wait = 0;
            end
            if (recv_wait > 0) begin
                recv_wait--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    function automatic logic [31:0] rnd_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h8000_0000 + $urandom_range(0, 3);
            2: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            default: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
        endcase
    endfunction

    function automatic t_req make_req(input logic op, input logic [31:0] ax, ay, az,
                                      input logic [31:0] bx, by, bz, input logic neg);
        t_req r;
        r.op = op; r.ax = ax; r.ay = ay; r.az = az;
        r.bx = bx; r.by = by; r.bz = bz; r.neg = neg;
        r.last = $urandom_range(0, 1);
        return r;
    endfunction

    task automatic wait_drain();
        while (pending_reqs.size() > 0 || expected_points.size() > 0 || i_in_valid)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [17:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_COS) cos_h = $signed(val);
        else sin_h = $signed(val);
    endtask

    task automatic random_phase(input int cnt);
        t_req r;
        for (int k = 0; k < cnt; k++) begin
            if ($urandom_range(0, 9) == 0)
                r = make_req(0, rnd_coord(), rnd_coord(), rnd_coord(),
                             rnd_coord(), rnd_coord(), rnd_coord(), $urandom_range(0, 1));
            else
                r = make_req(1, rnd_coord(), rnd_coord(), rnd_coord(),
                             $urandom, $urandom, $urandom, $urandom_range(0, 1));
            pending_reqs.push_back(r);
        end
    endtask

    initial begin
        reset_rotator();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        pending_reqs.push_back(make_req(1, 32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(0, 0, 0, 0, 32'h0001_0000, 0, 0, 0));
        pending_reqs.push_back(make_req(1, 32'h0000_0000, 32'h0003_0000, 0, 0, 0, 0, 1));
        pending_reqs.push_back(make_req(0, 0, 0, 0, 0, 0, 32'h0005_0000, 1));
        pending_reqs.push_back(make_req(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                                        0, 0, 0, 0));
        pending_reqs.push_back(make_req(0, 32'h1234_5678, 32'h1, 32'h2,
                                        32'h1234_5678, 32'h1, 32'h2, 0));
        pending_reqs.push_back(make_req(1, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1));
        pending_reqs.push_back(make_req(1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                        32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1));
        pending_reqs.push_back(make_req(0, 32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0, 0));
        pending_reqs.push_back(make_req(1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234, 0, 0, 0, 0));
        wait_drain();
        write_reg(CFG_COS, 18'h10000);
        write_reg(CFG_SIN, 18'h10000);
        pending_reqs.push_back(make_req(0, 0, 0, 0, 32'h0001_0000, 32'h0001_0000, 0, 0));
        random_phase(120);
        wait_drain();
        write_reg(CFG_COS, 18'h30000);
        write_reg(CFG_SIN, 18'h30000);
        random_phase(120);
        wait_drain();
        write_reg(CFG_COS, 18'h0B505);
        write_reg(CFG_SIN, 18'h34AFB);
        random_phase(120);
        wait_drain();
        write_reg(CFG_COS, 18'($urandom));
        write_reg(CFG_SIN, 18'($urandom));
        random_phase(130);
        wait_drain();
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
`default_nettype wire
